// ----- hw/rtl/pidaw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and fixed-point constants of the PID anti-windup controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DATA_W          = 16;
  localparam int ACC_W           = 32;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int INTEG_FRAC_BITS = 16;
  localparam int FILTER_LEN_LOG2 = 3;
  localparam int FILTER_LEN      = 1 << FILTER_LEN_LOG2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2,
    REG_OUT_FLOOR  = 2'd3
  } pidaw_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] gain_prop;
    logic [DATA_W-1:0] gain_integ;
    logic [DATA_W-1:0] gain_deriv;
    logic [DATA_W-1:0] out_floor;
  } pidaw_cfg_t;

endpackage

// ----- hw/rtl/pidaw_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_in_if
// Input channel: one error sample and the drive ceiling for that step.
// ----------------------------------------------------------------------------
interface pidaw_in_if;
  import pidaw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] error_sample;
  logic        [DATA_W-1:0] out_ceiling;

  modport source (output valid, output error_sample, output out_ceiling, input ready);
  modport sink   (input valid, input error_sample, input out_ceiling, output ready);
endinterface

// ----- hw/rtl/pidaw_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_out_if
// Result channel: one clamped drive value per input word.
// ----------------------------------------------------------------------------
interface pidaw_out_if;
  import pidaw_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

// ----- hw/rtl/pidaw_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_cfg_regs
// APB-style register file holding the gains and the drive floor.
// ----------------------------------------------------------------------------
module pidaw_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pidaw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pidaw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output pidaw_pkg::pidaw_cfg_t           cfg
);
  import pidaw_pkg::*;

  pidaw_cfg_t cfg_r;
  pidaw_cfg_t cfg_nxt;
  pidaw_reg_t reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = pidaw_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_GAIN_PROP:  cfg_nxt.gain_prop  = pwdata[DATA_W-1:0];
        REG_GAIN_INTEG: cfg_nxt.gain_integ = pwdata[DATA_W-1:0];
        REG_GAIN_DERIV: cfg_nxt.gain_deriv = pwdata[DATA_W-1:0];
        REG_OUT_FLOOR:  cfg_nxt.out_floor  = pwdata[DATA_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GAIN_PROP:  prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, cfg_r.gain_prop};
      REG_GAIN_INTEG: prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, cfg_r.gain_integ};
      REG_GAIN_DERIV: prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, cfg_r.gain_deriv};
      REG_OUT_FLOOR:  prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, cfg_r.out_floor};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/pidaw_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_core
// Input register, single-pass PID datapath with integrator clamp, controller
// state and output register.
// ----------------------------------------------------------------------------
module pidaw_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pidaw_pkg::pidaw_cfg_t            cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [pidaw_pkg::DATA_W-1:0] in_error_sample,
  input  logic        [pidaw_pkg::DATA_W-1:0] in_out_ceiling,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic        [pidaw_pkg::DATA_W-1:0] out_drive_value
);
  import pidaw_pkg::*;

  localparam int FNW = DATA_W + FILTER_LEN_LOG2 + 1;  // filter numerator
  localparam int PPW = 2 * DATA_W + 1;                // err * gain_prop
  localparam int CW  = 2 * DATA_W + 2;                // diff * gain_deriv, sums

  function automatic logic signed [CW-1:0] clamp_rng(
    input logic signed [CW-1:0] v,
    input logic [DATA_W-1:0]    lo,
    input logic [DATA_W-1:0]    hi
  );
    logic signed [CW-1:0] lo_s;
    logic signed [CW-1:0] hi_s;
    lo_s = $signed({{(CW-DATA_W){1'b0}}, lo});
    hi_s = $signed({{(CW-DATA_W){1'b0}}, hi});
    if (v < lo_s) begin
      clamp_rng = lo_s;
    end else if (v > hi_s) begin
      clamp_rng = hi_s;
    end else begin
      clamp_rng = v;
    end
  endfunction

  // stage registers
  logic                     s1_v_r, s1_v_nxt;
  logic signed [DATA_W-1:0] s1_err_r;
  logic        [DATA_W-1:0] s1_ceil_r;
  logic                     out_v_r, out_v_nxt;
  logic        [DATA_W-1:0] drive_r, drive_nxt;

  // controller state
  logic        [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DATA_W-1:0] filt_r, filt_nxt;

  logic accept;
  logic advance;

  // datapath
  logic signed [FNW-1:0]    f_err;
  logic signed [FNW-1:0]    f_old;
  logic signed [FNW-1:0]    f_num;
  logic signed [FNW-1:0]    f_bias;
  logic signed [FNW-1:0]    f_div;
  logic signed [DATA_W:0]   diff;
  logic signed [ACC_W-1:0]  i_prod;
  logic        [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  ipart;
  logic signed [CW-1:0]     ipart_x;
  logic signed [CW-1:0]     res_int;
  logic        [ACC_W-1:0]  acc_reload;
  logic signed [PPW-1:0]    p_prod;
  logic signed [PPW-1:0]    p_term;
  logic signed [CW-1:0]     d_prod;
  logic signed [CW-1:0]     d_term;
  logic signed [CW-1:0]     res_sum;
  logic signed [CW-1:0]     res_out;

  assign advance  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || advance;
  assign accept   = in_valid && in_ready;

  // error filter: (old*(N-1) + err)/N, truncated toward zero
  assign f_err  = {{(FNW-DATA_W){s1_err_r[DATA_W-1]}}, s1_err_r};
  assign f_old  = {{(FNW-DATA_W){filt_r[DATA_W-1]}}, filt_r};
  assign f_num  = (f_old <<< FILTER_LEN_LOG2) - f_old + f_err;
  assign f_bias = f_num[FNW-1] ? (f_num + FNW'(FILTER_LEN - 1)) : f_num;
  assign f_div  = f_bias >>> FILTER_LEN_LOG2;
  assign filt_nxt = f_div[DATA_W-1:0];

  assign diff = {s1_err_r[DATA_W-1], s1_err_r} - {filt_r[DATA_W-1], filt_r};

  // integrator, wraps at the accumulator width
  assign i_prod  = $signed({{(ACC_W-DATA_W){s1_err_r[DATA_W-1]}}, s1_err_r})
                 * $signed({{(ACC_W-DATA_W){1'b0}}, cfg.gain_integ});
  assign acc_sum = acc_r + i_prod;
  assign ipart   = $signed(acc_sum) >>> INTEG_FRAC_BITS;
  assign ipart_x = {{(CW-ACC_W){ipart[ACC_W-1]}}, ipart};
  assign res_int = clamp_rng(ipart_x, cfg.out_floor, s1_ceil_r);

  assign acc_reload = {{(ACC_W-DATA_W){1'b0}}, res_int[DATA_W-1:0]} << INTEG_FRAC_BITS;
  assign acc_nxt    = (res_int != ipart_x) ? acc_reload : acc_sum;

  // proportional and derivative terms
  assign p_prod = $signed({{(PPW-DATA_W){s1_err_r[DATA_W-1]}}, s1_err_r})
                * $signed({{(PPW-DATA_W){1'b0}}, cfg.gain_prop});
  assign p_term = p_prod >>> GAIN_FRAC_BITS;
  assign d_prod = $signed({{(CW-DATA_W-1){diff[DATA_W]}}, diff})
                * $signed({{(CW-DATA_W){1'b0}}, cfg.gain_deriv});
  assign d_term = d_prod >>> GAIN_FRAC_BITS;

  assign res_sum   = res_int + {{(CW-PPW){p_term[PPW-1]}}, p_term} + d_term;
  assign res_out   = clamp_rng(res_sum, cfg.out_floor, s1_ceil_r);
  assign drive_nxt = res_out[DATA_W-1:0];

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
      filt_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (advance) begin
        acc_r  <= acc_nxt;
        filt_r <= filt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r  <= in_error_sample;
      s1_ceil_r <= in_out_ceiling;
    end
    if (advance) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_drive_value = drive_r;

endmodule

// ----- hw/rtl/pid_controller_antiwindup_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// PID controller with filtered derivative and clamped Q16 integrator.
//
//   channel  dir  handshake            word
//   in_ch    in   valid/ready          error_sample (s16), out_ceiling (u16)
//   out_ch   out  valid/ready          drive_value (u16)
//   apb      in   psel/penable/pready  gain_prop, gain_integ, gain_deriv,
//                                      out_floor at 0x0, 0x4, 0x8, 0xc
//
// One word per cycle sustained while the result is not stalled; an accepted
// word passes the input register, then one pass through the datapath into
// the output register, which also updates integrator and filter state.
// Synchronous active-low reset clears gains, floor, state and valids.
// A stalled result holds while one more input word is still taken into the
// input register; input ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  pidaw_in_if.sink                         in_ch,
  pidaw_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pidaw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pidaw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import pidaw_pkg::*;

  pidaw_cfg_t cfg;

  pidaw_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidaw_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_error_sample (in_ch.error_sample),
    .in_out_ceiling  (in_ch.out_ceiling),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_drive_value (out_ch.drive_value)
  );

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // input back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a stalled result");

  // a word taken under a stalled result fills the input register
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && out_ch.valid && !out_ch.ready)
      |=> (in_ch.ready == out_ch.ready))
    else $error("input register not full after accept under stall");

endmodule
